[rtl/core/rfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    localparam logic [7:0]  HDR_FIRST  = 8'hEF;
    localparam logic [7:0]  HDR_SECOND = 8'h01;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_LENGTH = 16'd3;

    localparam logic [15:0] POS_HDR_SECOND = 16'd1;
    localparam logic [15:0] POS_ADDR_LAST  = 16'd5;
    localparam logic [15:0] POS_LEN_HIGH   = 16'd7;
    localparam logic [15:0] POS_LEN_LOW    = 16'd8;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER   = 3'd1;
    localparam logic [2:0] ST_BAD_ADDRESS  = 3'd2;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic        is_status;
        logic [2:0]  status;
        logic [7:0]  confirm_code;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
    } t_out;

endpackage

`default_nettype wire

[rtl/core/rfc_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfc_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire rfc_pkg::t_in  i_item,
    input  wire logic [31:0]   i_device_address,
    output logic               o_has_result,
    output rfc_pkg::t_out      o_result
);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_chk_high, n_chk_high;
    logic [7:0]  r_confirm, n_confirm;
    logic        r_finished, n_finished;
    logic        r_in_content, n_in_content;

    logic [15:0] b_pos, b_len, b_sum;
    logic [7:0]  b_chk_high, b_confirm;
    logic        b_in_content;
    logic        start;
    logic        active;
    logic [7:0]  rx;
    logic [7:0]  addr_byte;
    logic [15:0] sum_plus;
    logic [15:0] len_full;
    logic [16:0] pos_plus2;

    assign start        = i_item.frame_start;
    assign rx           = i_item.rx_byte;
    assign active       = start || !r_finished;
    assign b_pos        = start ? 16'd0 : r_pos;
    assign b_len        = start ? 16'd0 : r_len;
    assign b_sum        = start ? 16'd0 : r_sum;
    assign b_chk_high   = start ? 8'd0  : r_chk_high;
    assign b_confirm    = start ? 8'd0  : r_confirm;
    assign b_in_content = start ? 1'b0  : r_in_content;
    assign sum_plus     = b_sum + {8'd0, rx};
    assign len_full     = {b_len[15:8], rx};
    assign pos_plus2    = {1'b0, b_pos} + 17'd2;

    always_comb begin
        case (b_pos[2:0])
            3'd2:    addr_byte = i_device_address[31:24];
            3'd3:    addr_byte = i_device_address[23:16];
            3'd4:    addr_byte = i_device_address[15:8];
            default: addr_byte = i_device_address[7:0];
        endcase
    end

    always_comb begin
        n_pos        = r_pos;
        n_len        = r_len;
        n_sum        = r_sum;
        n_chk_high   = r_chk_high;
        n_confirm    = r_confirm;
        n_finished   = r_finished;
        n_in_content = r_in_content;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_step && active) begin
            n_pos        = b_pos;
            n_len        = b_len;
            n_sum        = b_sum;
            n_chk_high   = b_chk_high;
            n_confirm    = b_confirm;
            n_finished   = 1'b0;
            n_in_content = b_in_content;
            if (!b_in_content) begin
                if (b_pos == 16'd0 && rx != rfc_pkg::HDR_FIRST) begin
                    o_has_result    = 1'b1;
                    o_result.status = rfc_pkg::ST_BAD_HEADER;
                end else if (b_pos == rfc_pkg::POS_HDR_SECOND && rx != rfc_pkg::HDR_SECOND) begin
                    o_has_result    = 1'b1;
                    o_result.status = rfc_pkg::ST_BAD_HEADER;
                end else if (b_pos > rfc_pkg::POS_HDR_SECOND && b_pos <= rfc_pkg::POS_ADDR_LAST
                             && rx != addr_byte) begin
                    o_has_result    = 1'b1;
                    o_result.status = rfc_pkg::ST_BAD_ADDRESS;
                end else if (b_pos > rfc_pkg::POS_ADDR_LAST) begin
                    n_sum = sum_plus;
                    if (b_pos == rfc_pkg::POS_LEN_HIGH) begin
                        n_len = {rx, 8'd0};
                        n_pos = b_pos + 16'd1;
                    end else if (b_pos == rfc_pkg::POS_LEN_LOW) begin
                        n_len = len_full;
                        if (len_full < rfc_pkg::MIN_LENGTH) begin
                            o_has_result    = 1'b1;
                            o_result.status = rfc_pkg::ST_BAD_LENGTH;
                        end else begin
                            n_in_content = 1'b1;
                            n_pos        = 16'd0;
                        end
                    end else begin
                        n_pos = b_pos + 16'd1;
                    end
                end else begin
                    n_pos = b_pos + 16'd1;
                end
            end else begin
                n_pos = b_pos + 16'd1;
                if (b_pos == 16'd0) begin
                    n_confirm = rx;
                    n_sum     = sum_plus;
                end else if (pos_plus2 < {1'b0, b_len}) begin
                    n_sum                  = sum_plus;
                    o_has_result           = 1'b1;
                    o_result.payload_byte  = rx;
                    o_result.payload_index = b_pos - 16'd1;
                end else if (pos_plus2 == {1'b0, b_len}) begin
                    n_chk_high = rx;
                end else begin
                    o_has_result = 1'b1;
                    if ({b_chk_high, rx} != b_sum) begin
                        o_result.status = rfc_pkg::ST_BAD_CHECKSUM;
                    end else begin
                        o_result.status       = rfc_pkg::ST_OK;
                        o_result.confirm_code = b_confirm;
                    end
                end
            end
            if (o_has_result && o_result.is_status == 1'b0 && o_result.payload_byte == 8'd0
                && o_result.payload_index == 16'd0 && !(b_in_content && b_pos != 16'd0
                && pos_plus2 < {1'b0, b_len})) begin
                o_result.is_status = 1'b1;
                n_finished         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_len        <= '0;
            r_sum        <= '0;
            r_chk_high   <= '0;
            r_confirm    <= '0;
            r_finished   <= 1'b1;
            r_in_content <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_sum        <= n_sum;
            r_chk_high   <= n_chk_high;
            r_confirm    <= n_confirm;
            r_finished   <= n_finished;
            r_in_content <= n_in_content;
        end
    end

endmodule

`default_nettype wire

[rtl/core/response_frame_checker.sv]
// response_frame_checker
// Checks a response frame one received byte per transaction. The input
// channel (i_in_valid / o_in_ready, payload i_in) carries rx_byte and
// frame_start; frame_start restarts parsing at byte 0. The output channel
// (o_out_valid / i_out_ready, payload o_out) carries either a forwarded
// content byte with its index, or a status transaction that ends the frame
// (ok with confirmation code, bad header, bad address, bad checksum, bad
// length). Bytes that cause no result are consumed silently.
// The configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes
// the expected device address; it is always ready. It must be written only
// while the block is idle; the block itself does not enforce this.
// A byte is captured in the input register, parsed from there, and its
// result is registered in the result register that drives o_out.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the 16-bit sum and compare between the input and result registers.
// Reset (synchronous, active low) empties both registers, sets the address
// to all ones and waits for a frame start. When the receiver stalls, the
// result register holds, the input register fills, then o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module response_frame_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rfc_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rfc_pkg::t_out      o_out,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data
);

    logic          r_in_valid;
    rfc_pkg::t_in  r_in;
    logic          r_out_valid, n_out_valid;
    rfc_pkg::t_out r_out;
    logic [31:0]   r_device_address;
    logic          step;
    logic          has_result;
    rfc_pkg::t_out result;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    rfc_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (r_in),
        .i_device_address (r_device_address),
        .o_has_result     (has_result),
        .o_result         (result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = has_result;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_device_address <= rfc_pkg::ADDR_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_device_address <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (step && has_result) begin
            r_out <= result;
        end
    end

`ifndef SYNTHESIS
    a_fwd_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.is_status |-> o_out.status == rfc_pkg::ST_OK
                                            && o_out.confirm_code == 8'd0)
        else $error("forwarded byte carries status");

    a_err_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_status && o_out.status != rfc_pkg::ST_OK
            |-> o_out.confirm_code == 8'd0 && o_out.payload_index == 16'd0)
        else $error("error status carries data");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_status |-> o_out.status <= rfc_pkg::ST_BAD_LENGTH)
        else $error("status code out of range");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_in))
        else $error("input register lost a transaction");
`endif

endmodule

`default_nettype wire
